// ----- sv/dshot_frame_compare_sequencer_macros.svh -----
// Assertion helpers for the DShot frame compare sequencer.
// Both expect clk and rst_n in the scope where they are used.
`ifndef DSHOT_FRAME_COMPARE_SEQUENCER_MACROS_SVH
`define DSHOT_FRAME_COMPARE_SEQUENCER_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define DFCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define DFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dfcs_pkg.sv -----
`default_nettype none

package dfcs_pkg;

  // Frame and slot layout
  localparam int FRAME_BITS = 16;
  localparam int STOP_SLOTS = 2;
  localparam int SLOTS      = FRAME_BITS + STOP_SLOTS;
  localparam int SLOT_W     = 5;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Duty scaling: period*7/10 and period*3/10 (same as 70/100 and 30/100).
  // x/10 = (x * RECIP) >> RECIP_SHIFT, exact for x below 2^22.
  localparam int SCALED_W    = 19;
  localparam int RECIP_W     = 20;
  localparam int PROD_W      = SCALED_W + RECIP_W;
  localparam int RECIP_SHIFT = 23;
  localparam logic [SCALED_W-1:0] HI_MUL = SCALED_W'(7);
  localparam logic [SCALED_W-1:0] LO_MUL = SCALED_W'(3);
  localparam logic [RECIP_W-1:0]  RECIP  = RECIP_W'(838861);

  // Cycles for a new bit period to reach the compare values
  localparam logic [1:0] SETTLE_CYC = 2'd2;

  typedef struct packed {
    logic [10:0] throttle;
    logic        telemetry_request;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       compare_value;
    logic [SLOT_W-1:0] slot_index;
    logic              last_slot;
  } out_item_t;

  // Compare values and settle status from the period scaler
  typedef struct packed {
    logic [15:0] hi;
    logic [15:0] lo;
    logic        busy;
  } scale_t;

  // Frame handed from the input stage to the slot emitter
  typedef struct packed {
    logic                  valid;
    logic [FRAME_BITS-1:0] frame;
  } frm_t;

  // Build value, request bit and inverted nibble XOR checksum
  function automatic logic [FRAME_BITS-1:0] build_frame(input in_item_t it);
    logic [11:0] pl;
    logic [3:0]  csum;
    pl   = {it.throttle, it.telemetry_request};
    csum = ~(pl[3:0] ^ pl[7:4] ^ pl[11:8]);
    return {pl, csum};
  endfunction

endpackage

`default_nettype wire

// ----- sv/dfcs_period_scale.sv -----
`default_nettype none

module dfcs_period_scale (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_valid,
  input  wire logic [15:0]    cfg_data,
  output dfcs_pkg::scale_t    scale
);
  import dfcs_pkg::*;

  logic [15:0]         period_r;
  logic [SCALED_W-1:0] x_hi_r, x_lo_r;
  logic [PROD_W-1:0]   p_hi, p_lo;
  logic [15:0]         hi_r, lo_r;
  logic [1:0]          settle_r, settle_nxt;

  // Hold the bit period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd27;
    end else if (cfg_valid) begin
      period_r <= cfg_data;
    end
  end

  // Count down after reset or a write until the compare values follow
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_valid) begin
      settle_nxt = SETTLE_CYC;
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYC;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  // Stage one: scale the period by the duty numerators
  always_ff @(posedge clk) begin
    x_hi_r <= SCALED_W'(period_r) * HI_MUL;
    x_lo_r <= SCALED_W'(period_r) * LO_MUL;
  end

  // Stage two: divide by ten through the reciprocal
  assign p_hi = PROD_W'(x_hi_r) * PROD_W'(RECIP);
  assign p_lo = PROD_W'(x_lo_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    hi_r <= p_hi[RECIP_SHIFT +: 16];
    lo_r <= p_lo[RECIP_SHIFT +: 16];
  end

  assign scale.hi   = hi_r;
  assign scale.lo   = lo_r;
  assign scale.busy = (settle_r != 2'd0);

endmodule

`default_nettype wire

// ----- sv/dfcs_frame_build.sv -----
`default_nettype none

module dfcs_frame_build (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dfcs_pkg::in_item_t in_data,
  input  wire logic               busy,
  input  wire logic               take,
  output dfcs_pkg::frm_t          frm
);
  import dfcs_pkg::*;

  logic                  valid_r;
  logic [FRAME_BITS-1:0] frame_r;

  // Accept a request when the slot is free or being emptied this cycle, and not while settling
  assign in_ready = (!valid_r || take) && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the finished frame with its checksum
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_r <= build_frame(in_data);
    end
  end

  assign frm.valid = valid_r;
  assign frm.frame = frame_r;

endmodule

`default_nettype wire

// ----- sv/dfcs_slot_emit.sv -----
`default_nettype none

module dfcs_slot_emit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dfcs_pkg::frm_t   frm,
  output logic                  take,
  input  wire dfcs_pkg::scale_t scale,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output dfcs_pkg::out_item_t   out_data
);
  import dfcs_pkg::*;

  logic                  act_r;
  logic [FRAME_BITS-1:0] shift_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  ovld_r;
  out_item_t             out_r;
  logic                  adv, last;

  // Advance one slot while active, when the result register is free or being drained
  assign adv  = act_r && (!ovld_r || out_ready);
  assign last = (slot_r == LAST_SLOT);
  assign take = frm.valid && (!act_r || (adv && last));

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (take) begin
      act_r <= 1'b1;
    end else if (adv && last) begin
      act_r <= 1'b0;
    end
  end

  // Shift frame bits out MSB first; stop slots see zeros shifted in
  always_ff @(posedge clk) begin
    if (take) begin
      shift_r <= frm.frame;
      slot_r  <= '0;
    end else if (adv) begin
      shift_r <= {shift_r[FRAME_BITS-2:0], 1'b0};
      slot_r  <= slot_r + SLOT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv) begin
      ovld_r <= 1'b1;
    end else if (out_ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.compare_value <= shift_r[FRAME_BITS-1] ? scale.hi : scale.lo;
      out_r.slot_index    <= slot_r;
      out_r.last_slot     <= last;
    end
  end

  assign out_valid = ovld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- sv/dshot_frame_compare_sequencer.sv -----
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data: throttle, telemetry_request
// out     | output    | out_valid / out_ready | out_data: compare_value, slot_index, last_slot
// cfg     | input     | cfg_valid / cfg_ready | cfg_data: bit_period
//
// Each command yields 18 results, one per cycle while out_ready stays high.
// The next command is held in the input register while the current one emits.
// An accepted command passes through the input register and the slot sequencer before its first result is registered.
// After reset or a bit_period write, in_ready stays low while the
// compare values are recomputed. Reset is synchronous, active low.
// A low out_ready holds the result register and stalls the sequencer.
`default_nettype none

`include "dshot_frame_compare_sequencer_macros.svh"

module dshot_frame_compare_sequencer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dfcs_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dfcs_pkg::out_item_t     out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);
  import dfcs_pkg::*;

  scale_t scale;
  frm_t   frm;
  logic   take;

  // Always take register writes
  assign cfg_ready = 1'b1;

  dfcs_period_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .scale     (scale)
  );

  dfcs_frame_build u_build (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .busy     (scale.busy),
    .take     (take),
    .frm      (frm)
  );

  dfcs_slot_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm       (frm),
    .take      (take),
    .scale     (scale),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Checks
  `DFCS_ASSERT_NOW(a_no_accept_settling, scale.busy, !in_ready, "request taken while settling")
  `DFCS_ASSERT_NOW(a_last_is_final, out_valid && out_data.last_slot, out_data.slot_index == LAST_SLOT, "last flag on wrong slot")
  `DFCS_ASSERT_NEXT(a_slot_advance, out_valid && out_ready && !out_data.last_slot, out_valid && (out_data.slot_index == $past(out_data.slot_index) + SLOT_W'(1)), "slot sequence broken")
  `DFCS_ASSERT_NOW(a_take_needs_frame, take, frm.valid, "sequencer loaded an empty frame")

endmodule

`default_nettype wire
